@@ sv/kmcd_pkg.sv @@
// Package with the shared types, constants and helpers of the key matrix change detector.
package kmcd_pkg;

    localparam int ROW_COUNT  = 8;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 8;
    localparam int OFFSET_W   = 3;
    localparam int KEY_W      = ROW_W + OFFSET_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COL_W-1:0] COL_RELEASED = '1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] cols;
        logic [COL_W-1:0] diff;
    } t_job;

    // Offset (counted from the most significant column bit) of the first set bit.
    function automatic logic [OFFSET_W-1:0] first_offset(input logic [COL_W-1:0] diff);
        logic [OFFSET_W-1:0] off;
        off = '0;
        for (int k = COL_W - 1; k >= 0; k--) begin
            if (diff[COL_W-1-k]) begin
                off = OFFSET_W'(k);
            end
        end
        return off;
    endfunction

endpackage

@@ sv/key_matrix_change_detector_top.sv @@
// Top level of the key matrix change detector.
// Each input beat is one sampled matrix row (row number and eight active-low column
// levels). The block compares it with the stored byte for that row, which starts as
// all released, and emits one output beat per changed column, scanning from column
// bit 7 down; key_code is row*8 plus the column offset, pressed is the inverted level,
// and last_event marks the final beat of the sample. An input beat is taken while
// the queue is not full; a sample with no change produces nothing. A sample with n
// changed keys gives n output beats, one output beat per cycle while the output is
// not stalled, so the sustained rate is set by the event generator. A two-entry
// queue between the compare stage and the event generator lets input keep arriving
// while events are still being emitted or the output is stalled.
module key_matrix_change_detector_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_row_index,
    input  logic [7:0] i_column_bits,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_key_code,
    output logic       o_pressed,
    output logic       o_last_event
);
    import kmcd_pkg::*;

    logic push;
    t_job push_job;
    logic queue_full;
    logic job_valid;
    t_job job;
    logic pop;

    kmcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_row_index  (i_row_index),
        .i_column_bits(i_column_bits),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    kmcd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (queue_full),
        .o_valid(job_valid),
        .i_pop  (pop),
        .o_job  (job)
    );

    kmcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_key_code  (o_key_code),
        .o_pressed   (o_pressed),
        .o_last_event(o_last_event)
    );

endmodule

@@ sv/kmcd_front.sv @@
// Front end: accepts row samples, compares them with the stored snapshot and queues changes.
module kmcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [2:0]    i_row_index,
    input  logic [7:0]    i_column_bits,
    input  logic          i_queue_full,
    output logic          o_push,
    output kmcd_pkg::t_job o_job
);
    import kmcd_pkg::*;

    logic [COL_W-1:0] r_snapshot [ROW_COUNT];
    logic [COL_W-1:0] diff;
    logic             accept;
    logic             in_range;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign in_range   = 32'(i_row_index) < ROW_COUNT;
    assign diff       = in_range ? (r_snapshot[i_row_index[ROW_W-1:0]] ^ i_column_bits) : '0;

    assign o_push     = accept && in_range && (diff != '0);
    assign o_job.row  = i_row_index;
    assign o_job.cols = i_column_bits;
    assign o_job.diff = diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_snapshot[r] <= COL_RELEASED;
            end
        end else if (o_push) begin
            r_snapshot[i_row_index[ROW_W-1:0]] <= i_column_bits;
        end
    end

endmodule

@@ sv/kmcd_queue.sv @@
// Short queue of changed row samples between the front end and the event generator.
module kmcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kmcd_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output kmcd_pkg::t_job o_job
);
    import kmcd_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic              do_pop;

    assign o_full   = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid  = r_count != '0;
    assign o_job    = r_slot[r_rd_ptr];
    assign do_pop   = i_pop && o_valid;
    assign n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/kmcd_back.sv @@
// Back end: walks the changed columns of one sample and emits one key event per beat.
module kmcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  kmcd_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [5:0]     o_key_code,
    output logic           o_pressed,
    output logic           o_last_event
);
    import kmcd_pkg::*;

    logic                r_busy;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_cols;
    logic [COL_W-1:0]    r_diff;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_key_code;
    logic                r_pressed;
    logic                r_last;

    logic                out_free;
    logic                fire;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] bit_pos;
    logic [COL_W-1:0]    n_diff;
    logic                last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign fire     = r_busy && out_free;
    assign offset   = first_offset(r_diff);
    assign bit_pos  = OFFSET_W'(COL_W - 1) - offset;
    assign n_diff   = r_diff & ~(COL_W'(1) << bit_pos);
    assign last     = n_diff == '0;
    // A new sample is taken while idle, or as soon as the current one gives its final event.
    assign o_pop    = !r_busy || (fire && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= i_job_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job_valid) begin
            r_row  <= i_job.row;
            r_cols <= i_job.cols;
            r_diff <= i_job.diff;
        end else if (fire) begin
            r_diff <= n_diff;
        end
        if (fire) begin
            r_key_code <= {r_row, offset};
            r_pressed  <= ~r_cols[bit_pos];
            r_last     <= last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_key_code;
    assign o_pressed    = r_pressed;
    assign o_last_event = r_last;

endmodule
